@@ rtl/fan_step_hysteresis_control_top_macros.svh @@
// assertion macros shared by the rtl files
`ifndef FAN_STEP_HYSTERESIS_CONTROL_TOP_MACROS_SVH
`define FAN_STEP_HYSTERESIS_CONTROL_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/fshc_pkg.sv @@
`timescale 1ns / 1ps

package fshc_pkg;

   localparam int unsigned NUM_STEPS = 4;
   localparam logic [7:0] TOP_TEMP = 8'd255;
   localparam logic [7:0] BOTTOM_TEMP = 8'd0;

   localparam logic [3:0] STEP_LIMIT = (NUM_STEPS < 4) ? 4'(NUM_STEPS) : 4'd4;

   localparam logic [7:0] PCT_FULL = 8'd100;
   localparam logic [7:0] LEVEL_FULL = 8'd255;

   localparam logic [3:0] MUL_LAST = 4'd7;
   localparam logic [3:0] DIV_LAST = 4'd8;

   localparam logic [2:0] CSR_UP_THRESHOLDS = 3'd0;
   localparam logic [2:0] CSR_UP_LEVELS = 3'd1;
   localparam logic [2:0] CSR_DOWN_THRESHOLDS = 3'd2;
   localparam logic [2:0] CSR_DOWN_LEVELS = 3'd3;
   localparam logic [2:0] CSR_UP_STEP_COUNT = 3'd4;
   localparam logic [2:0] CSR_DOWN_STEP_COUNT = 3'd5;
   localparam logic [2:0] CSR_DUTY_PERCENT = 3'd6;
   localparam logic [2:0] CSR_STALL_PERCENT = 3'd7;

   typedef struct packed {
      logic       mode;
      logic [7:0] temperature;
   } fshc_req_type;

   typedef struct packed {
      logic [7:0] duty_level;
      logic       duty_written;
   } fshc_rsp_type;

   typedef struct packed {
      logic       start;
      logic [7:0] percent;
   } fshc_lvl_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] level;
   } fshc_lvl_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DELIVER
   } fshc_state_type;

   typedef enum logic [1:0] {
      LV_IDLE,
      LV_LOAD,
      LV_MUL,
      LV_DIV
   } fshc_lvl_state_type;

   typedef enum logic [1:0] {
      PH_STEP_SCALE,
      PH_STALL_SCALE,
      PH_BIAS,
      PH_DUTY
   } fshc_phase_type;

   function automatic logic [2:0] clamp_count(input logic [2:0] c);
      logic [3:0] ce;
      ce = {1'b0, c};
      if (ce > STEP_LIMIT) ce = STEP_LIMIT;
      if (ce == 4'd0) ce = 4'd1;
      return ce[2:0];
   endfunction

endpackage

@@ rtl/fshc_level.sv @@
`timescale 1ns / 1ps
`include "fan_step_hysteresis_control_top_macros.svh"

module fshc_level import fshc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  fshc_lvl_req_type lvl_req,
   input  logic [6:0]       stall_percent,
   input  logic [6:0]       duty_percent,
   output fshc_lvl_rsp_type lvl_rsp
);

   fshc_lvl_state_type state_ff, state_in;
   fshc_phase_type phase_ff;
   logic [3:0]  cnt_ff;
   logic        done_ff;
   logic [7:0]  p_ff;
   logic [7:0]  mcand_ff;
   logic [7:0]  mplier_ff;
   logic [15:0] acc_ff;
   logic [7:0]  rem_ff;
   logic [8:0]  q_ff;
   logic [7:0]  divisor_ff;
   logic [7:0]  t_ff;
   logic [7:0]  b0_ff;
   logic [7:0]  level_ff;

   logic load_en, mul_en, div_en, mul_last, div_last;
   logic [7:0]  pct_clamp, stall_clamp, diff;
   logic [7:0]  op_mcand, op_mplier, op_divisor;
   logic [8:0]  sum9;
   logic [15:0] acc_in;
   logic [8:0]  trial;
   logic        ge;
   logic [7:0]  rem_in;
   logic [8:0]  q_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LV_IDLE: begin
            if (lvl_req.start) state_in = LV_LOAD;
         end
         LV_LOAD: begin
            state_in = LV_MUL;
         end
         LV_MUL: begin
            if (cnt_ff == MUL_LAST) state_in = LV_DIV;
         end
         LV_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = (phase_ff == PH_DUTY) ? LV_IDLE : LV_LOAD;
         end
         default: begin
            state_in = LV_IDLE;
         end
      endcase
   end

   // control decode
   always_comb begin
      load_en = 1'b0;
      mul_en = 1'b0;
      div_en = 1'b0;
      case (state_ff)
         LV_LOAD: load_en = 1'b1;
         LV_MUL:  mul_en = 1'b1;
         LV_DIV:  div_en = 1'b1;
         default: begin
            load_en = 1'b0;
         end
      endcase
      mul_last = mul_en && (cnt_ff == MUL_LAST);
      div_last = div_en && (cnt_ff == DIV_LAST);
   end

   // operand select per phase
   always_comb begin
      pct_clamp = (p_ff > PCT_FULL) ? PCT_FULL : p_ff;
      stall_clamp = ({1'b0, stall_percent} > PCT_FULL) ? PCT_FULL : {1'b0, stall_percent};
      diff = (t_ff > q_ff[7:0]) ? (t_ff - q_ff[7:0]) : 8'd0;
      case (phase_ff)
         PH_STEP_SCALE: begin
            op_mcand = pct_clamp;
            op_mplier = LEVEL_FULL;
            op_divisor = PCT_FULL;
         end
         PH_STALL_SCALE: begin
            op_mcand = stall_clamp;
            op_mplier = LEVEL_FULL;
            op_divisor = PCT_FULL;
         end
         PH_BIAS: begin
            op_mcand = b0_ff;
            op_mplier = LEVEL_FULL - t_ff;
            op_divisor = LEVEL_FULL;
         end
         default: begin
            op_mcand = diff;
            op_mplier = {1'b0, duty_percent};
            op_divisor = PCT_FULL;
         end
      endcase
   end

   // shift-add multiply step, lsb first
   always_comb begin
      sum9 = {1'b0, acc_ff[15:8]} + (mplier_ff[0] ? {1'b0, mcand_ff} : 9'd0);
      acc_in = {sum9, acc_ff[7:1]};
   end

   // restoring divide step
   always_comb begin
      trial = {rem_ff, acc_ff[8]};
      ge = (trial >= {1'b0, divisor_ff});
      rem_in = ge ? 8'(trial - {1'b0, divisor_ff}) : trial[7:0];
      q_in = {q_ff[7:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LV_IDLE;
         phase_ff <= PH_STEP_SCALE;
         cnt_ff <= 4'd0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= div_last && (phase_ff == PH_DUTY);
         if (lvl_req.start) phase_ff <= PH_STEP_SCALE;
         else if (div_last && (phase_ff != PH_DUTY))
            phase_ff <= fshc_phase_type'(phase_ff + 2'd1);
         if (load_en || mul_last || div_last) cnt_ff <= 4'd0;
         else if (mul_en || div_en) cnt_ff <= cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (lvl_req.start) p_ff <= lvl_req.percent;
      if (load_en) begin
         mcand_ff <= op_mcand;
         mplier_ff <= op_mplier;
         divisor_ff <= op_divisor;
         acc_ff <= 16'd0;
      end
      if (mul_en) begin
         acc_ff <= acc_in;
         mplier_ff <= {1'b0, mplier_ff[7:1]};
         if (mul_last) rem_ff <= {1'b0, acc_in[15:9]};
      end
      if (div_en) begin
         rem_ff <= rem_in;
         q_ff <= q_in;
         acc_ff <= {acc_ff[14:0], 1'b0};
         if (div_last) begin
            case (phase_ff)
               PH_STEP_SCALE:  t_ff <= q_in[7:0];
               PH_STALL_SCALE: b0_ff <= q_in[7:0];
               PH_DUTY:        level_ff <= q_in[8] ? LEVEL_FULL : q_in[7:0];
               default: begin
                  t_ff <= t_ff;
               end
            endcase
         end
      end
   end

   assign lvl_rsp.done = done_ff;
   assign lvl_rsp.level = level_ff;

   `ASSERT_IMPLIES(a_rem_below_divisor, state_ff == LV_DIV, rem_ff < divisor_ff)
   `ASSERT_IMPLIES(a_start_when_idle, lvl_req.start, state_ff == LV_IDLE)
   `ASSERT_NEXT(a_done_after_duty, div_last && phase_ff == PH_DUTY, done_ff && state_ff == LV_IDLE)

endmodule

@@ rtl/fan_step_hysteresis_control_top.sv @@
`timescale 1ns / 1ps
`include "fan_step_hysteresis_control_top_macros.svh"
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_data (mode, temperature)
// rsp       out        rsp_valid/rsp_stall  rsp_data (duty_level, duty_written)
// csr       in         csr_wen              csr_index, csr_wdata
// a tick inside the band keeps the current duty and passes through ST_DELIVER
// a level update runs 4 passes of the bit-serial multiply and restoring divide
// (step scale, stall scale, bias, duty), plus accept and output load
// one transaction at a time; the next is taken once the result sits in the output register
// reset is synchronous and restores register defaults, no clearing pass
// rsp_stall holds the output register and ST_DELIVER; ST_IDLE still takes a transaction

module fan_step_hysteresis_control_top import fshc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fshc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fshc_rsp_type rsp_data,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   fshc_state_type state_ff, state_in;

   logic [31:0] up_thr_ff, up_lvl_ff, dn_thr_ff, dn_lvl_ff;
   logic [2:0]  up_cnt_ff, dn_cnt_ff;
   logic [6:0]  duty_pct_ff, stall_pct_ff;

   logic [7:0]  upper_bound_ff, lower_bound_ff, cur_duty_ff;
   logic [1:0]  upper_idx_ff, lower_idx_ff;

   logic [7:0]  pend_level_ff;
   logic        pend_written_ff;
   logic        rsp_valid_ff;
   fshc_rsp_type rsp_data_ff;

   fshc_lvl_req_type lvl_req;
   fshc_lvl_rsp_type lvl_rsp;

   logic        req_fire, hold_tick, out_free, deliver_en;
   logic [2:0]  up_n, dn_n;
   logic [7:0]  new_ub, new_lb, tick_p, p_sel;
   logic [1:0]  new_ui, new_li, mid;
   logic        in_band;

   // step search
   always_comb begin
      up_n = clamp_count(up_cnt_ff);
      dn_n = clamp_count(dn_cnt_ff);
      new_ub = TOP_TEMP;
      new_ui = 2'(up_n - 3'd1);
      for (int i = 3; i >= 0; i--) begin
         if ((3'(i) < up_n) && (req_data.temperature <= up_thr_ff[8*i +: 8])) begin
            new_ub = up_thr_ff[8*i +: 8];
            new_ui = 2'(i);
         end
      end
      new_lb = BOTTOM_TEMP;
      new_li = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if ((3'(i) < dn_n) && (req_data.temperature >= dn_thr_ff[8*i +: 8])) begin
            new_lb = dn_thr_ff[8*i +: 8];
            new_li = 2'(i);
         end
      end
      mid = 2'(({1'b0, new_ui} + {1'b0, new_li}) >> 1);
   end

   // step percent pick
   always_comb begin
      in_band = (req_data.temperature <= upper_bound_ff) &&
                (req_data.temperature >= lower_bound_ff);
      tick_p = 8'd0;
      if (req_data.temperature > upper_bound_ff) tick_p = up_lvl_ff[{upper_idx_ff, 3'b000} +: 8];
      if (req_data.temperature < lower_bound_ff) tick_p = dn_lvl_ff[{lower_idx_ff, 3'b000} +: 8];
      p_sel = req_data.mode ? up_lvl_ff[{mid, 3'b000} +: 8] : tick_p;
      hold_tick = !req_data.mode && in_band;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = hold_tick ? ST_DELIVER : ST_CALC;
         end
         ST_CALC: begin
            if (lvl_rsp.done) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the control
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      req_stall = 1'b1;
      deliver_en = 1'b0;
      case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_DELIVER: deliver_en = out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
      req_fire = req_valid && !req_stall;
      lvl_req.start = req_fire && !hold_tick;
      lvl_req.percent = p_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         up_thr_ff <= 32'd0;
         up_lvl_ff <= 32'd0;
         dn_thr_ff <= 32'd0;
         dn_lvl_ff <= 32'd0;
         up_cnt_ff <= 3'd4;
         dn_cnt_ff <= 3'd4;
         duty_pct_ff <= 7'd100;
         stall_pct_ff <= 7'd0;
         upper_bound_ff <= 8'd0;
         upper_idx_ff <= 2'd0;
         lower_bound_ff <= 8'd0;
         lower_idx_ff <= 2'd0;
         cur_duty_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_UP_THRESHOLDS:   up_thr_ff <= csr_wdata;
               CSR_UP_LEVELS:       up_lvl_ff <= csr_wdata;
               CSR_DOWN_THRESHOLDS: dn_thr_ff <= csr_wdata;
               CSR_DOWN_LEVELS:     dn_lvl_ff <= csr_wdata;
               CSR_UP_STEP_COUNT:   up_cnt_ff <= csr_wdata[2:0];
               CSR_DOWN_STEP_COUNT: dn_cnt_ff <= csr_wdata[2:0];
               CSR_DUTY_PERCENT:    duty_pct_ff <= csr_wdata[6:0];
               CSR_STALL_PERCENT:   stall_pct_ff <= csr_wdata[6:0];
               default: begin
                  up_thr_ff <= up_thr_ff;
               end
            endcase
         end
         // bounds move after the percent is taken from the old ones
         if (lvl_req.start) begin
            upper_bound_ff <= new_ub;
            upper_idx_ff <= new_ui;
            lower_bound_ff <= new_lb;
            lower_idx_ff <= new_li;
         end
         if (lvl_rsp.done) cur_duty_ff <= lvl_rsp.level;
         if (deliver_en) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && hold_tick) begin
         pend_level_ff <= cur_duty_ff;
         pend_written_ff <= 1'b0;
      end
      if (lvl_rsp.done) begin
         pend_level_ff <= lvl_rsp.level;
         pend_written_ff <= 1'b1;
      end
      if (deliver_en) begin
         rsp_data_ff.duty_level <= pend_level_ff;
         rsp_data_ff.duty_written <= pend_written_ff;
      end
   end

   fshc_level u_level (
      .clock         (clock),
      .reset         (reset),
      .lvl_req       (lvl_req),
      .stall_percent (stall_pct_ff),
      .duty_percent  (duty_pct_ff),
      .lvl_rsp       (lvl_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ASSERT_NEXT(a_hold_to_deliver, req_fire && hold_tick, state_ff == ST_DELIVER && !pend_written_ff)
   `ASSERT_NEXT(a_update_to_calc, req_fire && !hold_tick, state_ff == ST_CALC)
   `ASSERT_IMPLIES(a_done_in_calc, lvl_rsp.done, state_ff == ST_CALC)
   `ASSERT_IMPLIES(a_written_is_duty, state_ff == ST_DELIVER && pend_written_ff, pend_level_ff == cur_duty_ff)

endmodule
